@@ rtl/core/rc6_pkg.sv @@
// Package: shared types and constants for the RC6 block cipher
package rc6_pkg;
    localparam logic [31:0] P32 = 32'hB7E15163;
    localparam logic [31:0] Q32 = 32'h9E3779B9;

    localparam logic [2:0] CFG_KEY_SIZE = 3'd4;

    localparam logic [1:0] KEY_SIZE_16 = 2'd0;
    localparam logic [1:0] KEY_SIZE_24 = 2'd1;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_INIT,
        OP_MIX,
        OP_LOAD,
        OP_PRE,
        OP_ROUND,
        OP_POST
    } t_op;

    typedef struct packed {
        t_op  op;
        logic decrypt;
        logic first;
    } t_cmd;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} << n;
        return w[63:32];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] w;
        w = {x, x} >> n;
        return w[31:0];
    endfunction
endpackage

@@ rtl/core/rc6_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read
module rc6_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/rc6_datapath.sv @@
// RC6 datapath: key mixing registers, round registers and arithmetic
module rc6_datapath #(
    parameter int RKW = 6
) (
    input  logic              i_clk,
    input  rc6_pkg::t_cmd     i_cmd,
    input  logic [255:0]      i_key,
    input  logic [RKW-1:0]    i_wr_idx,
    input  logic [2:0]        i_lw_idx,
    input  logic [RKW-1:0]    i_rd_idx,
    input  logic [127:0]      i_block,
    output logic [127:0]      o_result
);
    import rc6_pkg::*;

    logic [31:0]  r_a, r_b, r_c, r_d;
    logic [31:0]  r_ma, r_mb, r_prev;
    logic [31:0]  r_lw [8];
    logic [31:0]  r_k0, r_k1;
    logic [31:0]  n_a, n_b, n_c, n_d;
    logic [31:0]  ram_rd;
    logic [RKW-1:0] ram_ra;
    logic         ram_we;
    logic [31:0]  ram_wd;
    logic [31:0]  mix_a, mix_b, t, u;

    // Key read: during mixing read the entry to be updated; else round key.
    assign ram_ra = i_rd_idx;

    rc6_ram #(.WIDTH(32), .DEPTH(2 ** RKW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_wr_idx),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    assign mix_a = rotl(ram_rd + r_ma + r_mb, 5'd3);
    assign mix_b = rotl(r_lw[i_lw_idx] + mix_a + r_mb, mix_a[4:0] + r_mb[4:0]);

    always_comb begin
        ram_we = 1'b0;
        ram_wd = mix_a;
        case (i_cmd.op)
            OP_INIT: begin
                ram_we = 1'b1;
                ram_wd = i_cmd.first ? P32 : r_prev + Q32;
            end
            OP_MIX: ram_we = 1'b1;
            default: ;
        endcase
    end

    // round function and pre-/post-whitening
    always_comb begin
        logic [31:0] a2, b2, c2, d2, pb, pd;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d;
        t = '0; u = '0;
        a2 = '0; b2 = '0; c2 = '0; d2 = '0; pb = '0; pd = '0;
        case (i_cmd.op)
            OP_PRE: begin
                if (i_cmd.decrypt) begin
                    n_c = r_c - r_k1;
                    n_a = r_a - r_k0;
                end else begin
                    n_b = r_b + r_k0;
                    n_d = r_d + r_k1;
                end
            end
            OP_ROUND: begin
                if (i_cmd.decrypt) begin
                    a2 = r_d; b2 = r_a; c2 = r_b; d2 = r_c;
                end else begin
                    a2 = r_a; b2 = r_b; c2 = r_c; d2 = r_d;
                end
                pb = b2 * {b2[30:0], 1'b1};
                pd = d2 * {d2[30:0], 1'b1};
                t = rotl(pb, 5'd5);
                u = rotl(pd, 5'd5);
                if (i_cmd.decrypt) begin
                    n_a = rotr(a2 - r_k0, u[4:0]) ^ t;
                    n_c = rotr(c2 - r_k1, t[4:0]) ^ u;
                    n_b = b2;
                    n_d = d2;
                end else begin
                    n_a = b2;
                    n_b = rotl(c2 ^ u, t[4:0]) + r_k1;
                    n_c = d2;
                    n_d = rotl(a2 ^ t, u[4:0]) + r_k0;
                end
            end
            OP_POST: begin
                if (i_cmd.decrypt) begin
                    n_d = r_d - r_k1;
                    n_b = r_b - r_k0;
                end else begin
                    n_a = r_a + r_k0;
                    n_c = r_c + r_k1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_IDLE: begin
                r_a <= i_block[31:0];
                r_b <= i_block[63:32];
                r_c <= i_block[95:64];
                r_d <= i_block[127:96];
            end
            OP_INIT: begin
                r_prev <= ram_wd;
                r_ma   <= '0;
                r_mb   <= '0;
                for (int k = 0; k < 8; k++) begin
                    r_lw[k] <= i_key[32*k +: 32];
                end
            end
            OP_MIX: begin
                r_ma <= mix_a;
                r_mb <= mix_b;
                r_lw[i_lw_idx] <= mix_b;
            end
            OP_LOAD: begin
                // second word of the pair arrives in the cycle after the first
                r_k0 <= r_k1;
                r_k1 <= ram_rd;
            end
            default: begin
                r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
                r_k0 <= r_k1;
                r_k1 <= ram_rd;
            end
        endcase
    end

    assign o_result = {r_d, r_c, r_b, r_a};
endmodule

@@ rtl/core/rc6_block_cipher.sv @@
// Top level: RC6-32 block cipher, controller and datapath
//  channel | dir | handshake          | payload
//  s_axis  | in  | tvalid/tready      | tuser=action, tdata={block_high,block_low}
//  m_axis  | out | tvalid/tready      | tdata={result_high,result_low}
//  cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
// An input transfer runs the key fetch, pre-whitening, the rounds and post-whitening; each step
// first reads its key pair from the key RAM, and the result is then held for the output transfer.
// The next block is taken only after the output transfer, once the controller is back in S_IDLE.
// After a key or key-size write, the next block first runs key expansion: fill, then mixing.
// Synchronous active-low reset clears control; key registers reset to zero.
// A held result blocks the next block until it is taken.
module rc6_block_cipher #(
    parameter int ROUNDS = 20
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_low, block_high
    input  logic         s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_low, result_high
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import rc6_pkg::*;

    localparam int NRK = 2 * ROUNDS + 4;
    localparam int RKW = $clog2(NRK);
    localparam int CW  = $clog2(3 * NRK + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_MIX, S_LOAD, S_PRE, S_ROUND, S_POST, S_OUT
    } t_state;

    t_state         r_state;
    logic [255:0]   r_key;
    logic [1:0]     r_size;
    logic           r_ready;
    logic           r_dec;
    logic [RKW-1:0] r_wi, r_ri;
    logic [2:0]     r_j;
    logic [CW-1:0]  r_cnt;
    logic           r_ph;
    logic [5:0]     r_rnd;
    logic [2:0]     key_last;
    logic [CW-1:0]  steps;
    t_cmd           cmd;
    logic [127:0]   result;

    assign key_last = (r_size == KEY_SIZE_16) ? 3'd3 : (r_size == KEY_SIZE_24) ? 3'd5 : 3'd7;
    assign steps = CW'(3 * NRK);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata = result;

    always_comb begin
        cmd.decrypt = r_dec;
        cmd.first = (r_wi == '0);
        case (r_state)
            S_INIT:  cmd.op = OP_INIT;
            S_MIX:   cmd.op = r_ph ? OP_MIX : OP_LOAD;
            S_LOAD:  cmd.op = OP_LOAD;
            S_PRE:   cmd.op = r_ph ? OP_PRE : OP_LOAD;
            S_ROUND: cmd.op = r_ph ? OP_ROUND : OP_LOAD;
            S_POST:  cmd.op = r_ph ? OP_POST : OP_LOAD;
            S_IDLE:  cmd.op = OP_IDLE;
            default: cmd.op = OP_LOAD;
        endcase
    end

    rc6_datapath #(.RKW(RKW)) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_key      (r_key),
        .i_wr_idx   (r_wi),
        .i_lw_idx   (r_j),
        .i_rd_idx   (r_ri),
        .i_block    (s_axis_tdata),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_key   <= '0;
            r_size  <= '0;
            r_ready <= 1'b0;
            r_dec   <= 1'b0;
            r_wi    <= '0;
            r_ri    <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_ph    <= 1'b0;
            r_rnd   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index < CFG_KEY_SIZE) begin
                            r_key[64*i_cfg_index[1:0] +: 64] <= i_cfg_data;
                            r_ready <= 1'b0;
                        end else if (i_cfg_index == CFG_KEY_SIZE) begin
                            r_size  <= i_cfg_data[1:0];
                            r_ready <= 1'b0;
                        end
                    end else if (s_axis_tvalid) begin
                        r_dec <= s_axis_tuser;
                        r_wi  <= '0;
                        if (r_ready) begin
                            r_ri    <= s_axis_tuser ? RKW'(NRK - 2) : '0;
                            r_ph    <= 1'b0;
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (r_wi == RKW'(NRK - 1)) begin
                        r_wi    <= '0;
                        r_ri    <= '0;
                        r_j     <= '0;
                        r_cnt   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_MIX;
                    end else begin
                        r_wi <= r_wi + 1'b1;
                    end
                end
                S_MIX: begin
                    // read then update one entry; the entry is read in the first phase and written in the second
                    if (r_ph) begin
                        r_wi  <= (r_wi == RKW'(NRK - 1)) ? '0 : r_wi + 1'b1;
                        r_j   <= (r_j == key_last) ? '0 : r_j + 1'b1;
                        r_ph  <= 1'b0;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == steps - 1'b1) begin
                            r_ready <= 1'b1;
                            r_ri    <= r_dec ? RKW'(NRK - 2) : '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_ri <= (r_ri == RKW'(NRK - 1)) ? '0 : r_ri + 1'b1;
                        end
                    end else begin
                        r_ph <= 1'b1;
                    end
                end
                S_LOAD: begin
                    // fetch the first key pair of the whitening
                    if (!r_ph) begin
                        r_ri <= r_ri + 1'b1;
                        r_ph <= 1'b1;
                    end else begin
                        r_ri    <= r_dec ? RKW'(NRK - 4) : RKW'(2);
                        r_ph    <= 1'b0;
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    if (!r_ph) begin
                        r_ri <= r_ri + 1'b1;
                        r_ph <= 1'b1;
                    end else begin
                        r_ri    <= r_dec ? r_ri - RKW'(3) : r_ri + 1'b1;
                        r_ph    <= 1'b0;
                        r_rnd   <= 6'(ROUNDS);
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (!r_ph) begin
                        r_ri <= r_ri + 1'b1;
                        r_ph <= 1'b1;
                    end else begin
                        r_ph  <= 1'b0;
                        r_rnd <= r_rnd - 1'b1;
                        if (r_rnd == 6'd1) begin
                            r_ri    <= r_dec ? '0 : RKW'(NRK - 2);
                            r_state <= S_POST;
                        end else begin
                            r_ri <= r_dec ? r_ri - RKW'(3) : r_ri + 1'b1;
                        end
                    end
                end
                S_POST: begin
                    if (!r_ph) begin
                        r_ri <= r_ri + 1'b1;
                        r_ph <= 1'b1;
                    end else begin
                        r_ph    <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
